/* design/rpwdr_pkg.sv */
// ============================================================================
// rpwdr_pkg: shared types and constants for the rotated pixel writer
// Widths of the request and result fields, request and register codes, and
// the structs that travel between the front end, the queue and the back end.
// ============================================================================
package rpwdr_pkg;

    // Panel limits and the default framebuffer size.
    localparam int MAX_WIDTH    = 512;
    localparam int MAX_HEIGHT   = 512;
    localparam int FB_BYTES_DEF = 32768;

    // Register values after reset.
    localparam int RST_WIDTH  = 400;
    localparam int RST_HEIGHT = 300;

    // Field widths.
    localparam int REQ_W    = 2;
    localparam int DIM_W    = 10;
    localparam int COLOR_W  = 8;
    localparam int BADDR_W  = 15;
    localparam int COORD_W  = 9;
    localparam int STRIDE_W = 7;
    localparam int BYTES_W  = 16;
    localparam int CFG_IDX_W = 2;

    // Command queue depth between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef logic [REQ_W-1:0] t_req;

    // Request kinds.
    localparam t_req REQ_DRAW  = 2'd0;
    localparam t_req REQ_FILL  = 2'd1;
    localparam t_req REQ_CLEAR = 2'd2;
    localparam t_req REQ_READ  = 2'd3;

    // Rotation codes, quarter turns clockwise.
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;

    typedef struct packed {
        logic [1:0]       rot;
        logic [DIM_W-1:0] nw;
        logic [DIM_W-1:0] nh;
    } t_cfg;

    // Panel geometry derived from the configuration.
    typedef struct packed {
        logic [DIM_W-1:0]    eff_w;
        logic [DIM_W-1:0]    eff_h;
        logic [STRIDE_W-1:0] stride;
        logic [BYTES_W-1:0]  buf_bytes;
    } t_geom;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        t_req               op;
        logic               err;
        logic               color;
        logic [BADDR_W-1:0] addr;
        logic [COORD_W-1:0] nx;
        logic [COORD_W-1:0] ny;
    } t_cmd;

    typedef struct packed {
        logic               vld;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
    } t_dirty;

    localparam t_dirty DIRTY_RST = '{
        vld: 1'b1,
        x:   '0,
        y:   '0,
        w:   DIM_W'(RST_WIDTH),
        h:   DIM_W'(RST_HEIGHT)
    };

    typedef struct packed {
        logic               status;
        logic [COLOR_W-1:0] rdata;
        t_dirty             dirty;
    } t_result;

endpackage

/* design/rotated_pixel_writer_dirty_rect_top.sv */
// ============================================================================
// rotated_pixel_writer_dirty_rect_top: 1-bit e-paper framebuffer writer
// Rotated pixel drawing, fill, dirty rectangle tracking and byte reads.
// ============================================================================
// After reset the block clears the frame store to all ones, one byte a cycle;
// s_axis_tready stays low until that pass is done, while configuration
// writes are taken at any time. Each request beat gives exactly one result
// beat, in order. In the engine a draw reads the byte and writes it back, a
// read reads the byte, a clear-dirty or a rejected request finishes straight
// from the idle state, and a fill writes every framebuffer byte (stride times
// height, capped at the store size). Requests pass a two-stage classifier and
// a two-entry command queue first, so intake runs ahead of the engine, and a
// finished result waits in its own output register without blocking new work.
// ============================================================================
module rotated_pixel_writer_dirty_rect_top #(
    parameter int FB_BYTES = rpwdr_pkg::FB_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [rpwdr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rpwdr_pkg::DIM_W-1:0]         i_cfg_data,
    // Request stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: pos_x[9:0], pos_y[19:10], color[27:20], byte_addr[42:28], zero[47:43]
    input  logic [47:0]                         s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [rpwdr_pkg::REQ_W-1:0]         s_axis_tuser,
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: status[0], read_data[8:1], dirty_flag[9], dirty_left[18:10],
    //        dirty_top[27:19], dirty_width[37:28], dirty_height[47:38]
    output logic [47:0]                         m_axis_tdata
);

    rpwdr_pkg::t_cfg    r_cfg;
    rpwdr_pkg::t_geom   geom;
    rpwdr_pkg::t_cmd    fr_cmd;
    rpwdr_pkg::t_cmd    q_cmd;
    rpwdr_pkg::t_result res;
    logic               init_busy;
    logic               fr_push;
    logic               q_full;
    logic               q_vld;
    logic               q_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{rot: rpwdr_pkg::ROT_0,
                       nw:  rpwdr_pkg::DIM_W'(rpwdr_pkg::RST_WIDTH),
                       nh:  rpwdr_pkg::DIM_W'(rpwdr_pkg::RST_HEIGHT)};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rpwdr_pkg::CFG_ROTATION: r_cfg.rot <= i_cfg_data[1:0];
                rpwdr_pkg::CFG_WIDTH:    r_cfg.nw  <= i_cfg_data;
                rpwdr_pkg::CFG_HEIGHT:   r_cfg.nh  <= i_cfg_data;
                default:                 r_cfg     <= r_cfg;
            endcase
        end
    end

    rpwdr_front #(
        .FB_BYTES (FB_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_hold      (init_busy),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_req       (s_axis_tuser),
        .i_pos_x     (s_axis_tdata[9:0]),
        .i_pos_y     (s_axis_tdata[19:10]),
        .i_color     (s_axis_tdata[27:20]),
        .i_byte_addr (s_axis_tdata[42:28]),
        .o_geom      (geom),
        .i_q_full    (q_full),
        .o_push      (fr_push),
        .o_cmd       (fr_cmd)
    );

    rpwdr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_cmd   (fr_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_cmd   (q_cmd)
    );

    rpwdr_back #(
        .FB_BYTES (FB_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .o_init_busy (init_busy),
        .i_q_vld     (q_vld),
        .i_q_cmd     (q_cmd),
        .o_pop       (q_pop),
        .o_res_vld   (m_axis_tvalid),
        .i_res_rdy   (m_axis_tready),
        .o_res       (res)
    );

    // Result beat packing, first field in the lowest bits.
    assign m_axis_tdata = {res.dirty.h, res.dirty.w, res.dirty.y, res.dirty.x,
                           res.dirty.vld, res.rdata, res.status};

endmodule

/* design/rpwdr_front.sv */
// ============================================================================
// rpwdr_front: request intake and classification
// Takes request beats, checks them against the rotated panel size, maps draw
// points to native coordinates and byte addresses, and pushes commands.
// ============================================================================
module rpwdr_front #(
    parameter int FB_BYTES = rpwdr_pkg::FB_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rpwdr_pkg::t_cfg                   i_cfg,
    input  logic                              i_hold,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  rpwdr_pkg::t_req                   i_req,
    input  logic [rpwdr_pkg::DIM_W-1:0]       i_pos_x,
    input  logic [rpwdr_pkg::DIM_W-1:0]       i_pos_y,
    input  logic [rpwdr_pkg::COLOR_W-1:0]     i_color,
    input  logic [rpwdr_pkg::BADDR_W-1:0]     i_byte_addr,
    output rpwdr_pkg::t_geom                  o_geom,
    input  logic                              i_q_full,
    output logic                              o_push,
    output rpwdr_pkg::t_cmd                   o_cmd
);

    typedef struct packed {
        rpwdr_pkg::t_req                  req;
        logic [rpwdr_pkg::DIM_W-1:0]      pos_x;
        logic [rpwdr_pkg::DIM_W-1:0]      pos_y;
        logic [rpwdr_pkg::COLOR_W-1:0]    color;
        logic [rpwdr_pkg::BADDR_W-1:0]    baddr;
    } t_stage_a;

    typedef struct packed {
        rpwdr_pkg::t_req                  op;
        logic                             err;
        logic                             color;
        logic [rpwdr_pkg::COORD_W-1:0]    nx;
        logic [rpwdr_pkg::COORD_W-1:0]    ny;
        logic [rpwdr_pkg::BADDR_W-1:0]    baddr;
    } t_stage_b;

    logic     r_a_vld;
    t_stage_a r_a;
    logic     r_b_vld;
    t_stage_b r_b;

    logic [rpwdr_pkg::STRIDE_W-1:0] r_stride;
    logic [rpwdr_pkg::BYTES_W-1:0]  r_buf_bytes;

    logic [rpwdr_pkg::DIM_W-1:0]    eff_w;
    logic [rpwdr_pkg::DIM_W-1:0]    eff_h;
    logic [rpwdr_pkg::STRIDE_W-1:0] stride_c;
    logic [rpwdr_pkg::BYTES_W-1:0]  bytes_c;

    logic                           b_push;
    logic                           b_free;
    logic                           a_move;

    logic [rpwdr_pkg::DIM_W-1:0]    a_lw;
    logic [rpwdr_pkg::DIM_W-1:0]    a_lh;
    logic [rpwdr_pkg::DIM_W-1:0]    a_nx;
    logic [rpwdr_pkg::DIM_W-1:0]    a_ny;
    logic                           a_color_bad;
    logic                           a_range_bad;
    logic                           a_err;

    logic [rpwdr_pkg::BYTES_W-1:0]  b_row_base;
    logic [rpwdr_pkg::BYTES_W-1:0]  b_draw_addr;
    logic                           b_err;

    // Effective panel size, clamped to the supported maximum.
    always_comb begin
        eff_w = i_cfg.nw;
        eff_h = i_cfg.nh;
        if (32'(i_cfg.nw) > 32'(rpwdr_pkg::MAX_WIDTH)) begin
            eff_w = rpwdr_pkg::DIM_W'(rpwdr_pkg::MAX_WIDTH);
        end
        if (32'(i_cfg.nh) > 32'(rpwdr_pkg::MAX_HEIGHT)) begin
            eff_h = rpwdr_pkg::DIM_W'(rpwdr_pkg::MAX_HEIGHT);
        end
    end

    // Row stride in bytes and the buffer size, capped at the store size.
    assign stride_c = rpwdr_pkg::STRIDE_W'((11'(eff_w) + 11'd7) >> 3);
    assign bytes_c  = rpwdr_pkg::BYTES_W'(stride_c) * rpwdr_pkg::BYTES_W'(eff_h);

    always_ff @(posedge i_clk) begin
        r_stride <= stride_c;
        if (32'(bytes_c) > 32'(FB_BYTES)) begin
            r_buf_bytes <= rpwdr_pkg::BYTES_W'(FB_BYTES);
        end else begin
            r_buf_bytes <= bytes_c;
        end
    end

    assign o_geom = '{eff_w: eff_w, eff_h: eff_h, stride: r_stride, buf_bytes: r_buf_bytes};

    // Two-stage flow control; a stage moves on when the next one frees up.
    assign b_push  = r_b_vld && !i_q_full;
    assign b_free  = !r_b_vld || b_push;
    assign a_move  = r_a_vld && b_free;
    assign o_ready = !i_hold && (!r_a_vld || a_move);

    // First stage: range checks and rotation to native coordinates.
    always_comb begin
        a_lw = eff_w;
        a_lh = eff_h;
        if (i_cfg.rot[0]) begin
            a_lw = eff_h;
            a_lh = eff_w;
        end
        a_color_bad = r_a.color > rpwdr_pkg::COLOR_W'(1);
        a_range_bad = (r_a.pos_x >= a_lw) || (r_a.pos_y >= a_lh);
        case (i_cfg.rot)
            rpwdr_pkg::ROT_90: begin
                a_nx = eff_w - rpwdr_pkg::DIM_W'(1) - r_a.pos_y;
                a_ny = r_a.pos_x;
            end
            rpwdr_pkg::ROT_180: begin
                a_nx = eff_w - rpwdr_pkg::DIM_W'(1) - r_a.pos_x;
                a_ny = eff_h - rpwdr_pkg::DIM_W'(1) - r_a.pos_y;
            end
            rpwdr_pkg::ROT_270: begin
                a_nx = r_a.pos_y;
                a_ny = eff_h - rpwdr_pkg::DIM_W'(1) - r_a.pos_x;
            end
            default: begin
                a_nx = r_a.pos_x;
                a_ny = r_a.pos_y;
            end
        endcase
        case (r_a.req)
            rpwdr_pkg::REQ_DRAW: a_err = a_color_bad || a_range_bad;
            rpwdr_pkg::REQ_FILL: a_err = a_color_bad;
            default:             a_err = 1'b0;
        endcase
    end

    // Second stage: byte address of the pixel and the address checks.
    assign b_row_base  = rpwdr_pkg::BYTES_W'(r_b.ny) * rpwdr_pkg::BYTES_W'(r_stride);
    assign b_draw_addr = b_row_base + rpwdr_pkg::BYTES_W'(r_b.nx >> 3);

    always_comb begin
        case (r_b.op)
            rpwdr_pkg::REQ_DRAW: b_err = r_b.err || (32'(b_draw_addr) >= 32'(FB_BYTES));
            rpwdr_pkg::REQ_READ: b_err = !((rpwdr_pkg::BYTES_W'(r_b.baddr) < r_buf_bytes)
                                           && (32'(r_b.baddr) < 32'(FB_BYTES)));
            default:             b_err = r_b.err;
        endcase
        o_cmd.op    = r_b.op;
        o_cmd.err   = b_err;
        o_cmd.color = r_b.color;
        o_cmd.nx    = r_b.nx;
        o_cmd.ny    = r_b.ny;
        if (r_b.op == rpwdr_pkg::REQ_READ) begin
            o_cmd.addr = r_b.baddr;
        end else begin
            o_cmd.addr = b_draw_addr[rpwdr_pkg::BADDR_W-1:0];
        end
    end

    assign o_push = b_push;

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_a_vld <= 1'b1;
            end else if (a_move) begin
                r_a_vld <= 1'b0;
            end
            if (a_move) begin
                r_b_vld <= 1'b1;
            end else if (b_push) begin
                r_b_vld <= 1'b0;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_a <= '{req: i_req, pos_x: i_pos_x, pos_y: i_pos_y,
                     color: i_color, baddr: i_byte_addr};
        end
        if (a_move) begin
            r_b <= '{op: r_a.req, err: a_err, color: r_a.color[0],
                     nx: a_nx[rpwdr_pkg::COORD_W-1:0], ny: a_ny[rpwdr_pkg::COORD_W-1:0],
                     baddr: r_a.baddr};
        end
    end

endmodule

/* design/rpwdr_queue.sv */
// ============================================================================
// rpwdr_queue: command queue between front and back
// A short first-in first-out buffer of classified commands.
// ============================================================================
module rpwdr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rpwdr_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_vld,
    output rpwdr_pkg::t_cmd o_cmd
);

    localparam int PTR_W = (rpwdr_pkg::QUEUE_DEPTH > 1) ? $clog2(rpwdr_pkg::QUEUE_DEPTH) : 1;

    rpwdr_pkg::t_cmd  r_ent [rpwdr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_cnt;

    assign o_full = r_cnt == (PTR_W+1)'(rpwdr_pkg::QUEUE_DEPTH);
    assign o_vld  = r_cnt != '0;
    assign o_cmd  = r_ent[r_rd];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (PTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr] <= i_cmd;
        end
    end

endmodule

/* design/rpwdr_back.sv */
// ============================================================================
// rpwdr_back: framebuffer and dirty rectangle engine
// Owns the frame store and the dirty rectangle, runs the clearing pass after
// reset, executes commands in order and holds the result register.
// ============================================================================
module rpwdr_back #(
    parameter int FB_BYTES = rpwdr_pkg::FB_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpwdr_pkg::t_geom  i_geom,
    output logic              o_init_busy,
    input  logic              i_q_vld,
    input  rpwdr_pkg::t_cmd   i_q_cmd,
    output logic              o_pop,
    output logic              o_res_vld,
    input  logic              i_res_rdy,
    output rpwdr_pkg::t_result o_res
);

    localparam int FB_AW = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;
    localparam logic [FB_AW-1:0] INIT_LAST = FB_AW'(FB_BYTES - 1);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RMW  = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_FILL = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [7:0]                       r_mem [FB_BYTES];
    logic [7:0]                       r_rd_data;

    logic [2:0]                       r_state, n_state;
    logic [FB_AW-1:0]                 r_init_idx, n_init_idx;
    logic [rpwdr_pkg::BYTES_W-1:0]    r_fill_idx, n_fill_idx;
    rpwdr_pkg::t_cmd                  r_cmd, n_cmd;
    rpwdr_pkg::t_dirty                r_dirty, n_dirty;
    logic                             r_status, n_status;
    logic [rpwdr_pkg::COLOR_W-1:0]    r_rdata, n_rdata;
    logic                             r_out_vld, n_out_vld;
    rpwdr_pkg::t_result               r_out, n_out;

    logic                             mem_we;
    logic [FB_AW-1:0]                 mem_waddr;
    logic [7:0]                       mem_wdata;
    logic                             mem_re;
    logic [FB_AW-1:0]                 mem_raddr;
    logic                             finish;
    logic                             out_free;
    logic [7:0]                       pix_mask;

    rpwdr_pkg::t_dirty                mg_dirty;
    rpwdr_pkg::t_dirty                full_dirty;
    logic [rpwdr_pkg::COORD_W-1:0]    mg_x0;
    logic [rpwdr_pkg::COORD_W-1:0]    mg_y0;
    logic [rpwdr_pkg::DIM_W:0]        mg_x1;
    logic [rpwdr_pkg::DIM_W:0]        mg_y1;
    logic [rpwdr_pkg::DIM_W:0]        end_px;
    logic [rpwdr_pkg::DIM_W:0]        end_py;
    logic [rpwdr_pkg::DIM_W:0]        end_dx;
    logic [rpwdr_pkg::DIM_W:0]        end_dy;

    assign out_free    = !r_out_vld || i_res_rdy;
    assign pix_mask    = 8'h80 >> r_cmd.nx[2:0];
    assign o_init_busy = r_state == S_INIT;
    assign o_res_vld   = r_out_vld;
    assign o_res       = r_out;

    assign full_dirty = '{vld: 1'b1, x: '0, y: '0, w: i_geom.eff_w, h: i_geom.eff_h};

    // Union of the current rectangle with the pixel of the pending draw.
    always_comb begin
        end_px = (rpwdr_pkg::DIM_W+1)'(r_cmd.nx) + (rpwdr_pkg::DIM_W+1)'(1);
        end_py = (rpwdr_pkg::DIM_W+1)'(r_cmd.ny) + (rpwdr_pkg::DIM_W+1)'(1);
        end_dx = (rpwdr_pkg::DIM_W+1)'(r_dirty.x) + (rpwdr_pkg::DIM_W+1)'(r_dirty.w);
        end_dy = (rpwdr_pkg::DIM_W+1)'(r_dirty.y) + (rpwdr_pkg::DIM_W+1)'(r_dirty.h);
        mg_x0  = (r_cmd.nx < r_dirty.x) ? r_cmd.nx : r_dirty.x;
        mg_y0  = (r_cmd.ny < r_dirty.y) ? r_cmd.ny : r_dirty.y;
        mg_x1  = (end_px > end_dx) ? end_px : end_dx;
        mg_y1  = (end_py > end_dy) ? end_py : end_dy;
        if (!r_dirty.vld) begin
            mg_dirty = '{vld: 1'b1, x: r_cmd.nx, y: r_cmd.ny,
                         w: rpwdr_pkg::DIM_W'(1), h: rpwdr_pkg::DIM_W'(1)};
        end else begin
            mg_dirty.vld = 1'b1;
            mg_dirty.x   = mg_x0;
            mg_dirty.y   = mg_y0;
            mg_dirty.w   = rpwdr_pkg::DIM_W'(mg_x1 - (rpwdr_pkg::DIM_W+1)'(mg_x0));
            mg_dirty.h   = rpwdr_pkg::DIM_W'(mg_y1 - (rpwdr_pkg::DIM_W+1)'(mg_y0));
        end
    end

    // Command sequencer.
    always_comb begin
        n_state    = r_state;
        n_init_idx = r_init_idx;
        n_fill_idx = r_fill_idx;
        n_cmd      = r_cmd;
        n_dirty    = r_dirty;
        n_status   = r_status;
        n_rdata    = r_rdata;
        n_out_vld  = r_out_vld && !i_res_rdy;
        n_out      = r_out;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        o_pop      = 1'b0;
        finish     = 1'b0;
        case (r_state)
            S_INIT: begin
                mem_we     = 1'b1;
                mem_waddr  = r_init_idx;
                mem_wdata  = 8'hFF;
                n_init_idx = r_init_idx + FB_AW'(1);
                if (r_init_idx == INIT_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_vld) begin
                    o_pop    = 1'b1;
                    n_cmd    = i_q_cmd;
                    n_status = i_q_cmd.err;
                    n_rdata  = '0;
                    if (i_q_cmd.err) begin
                        finish = 1'b1;
                    end else begin
                        case (i_q_cmd.op)
                            rpwdr_pkg::REQ_DRAW: begin
                                mem_re    = 1'b1;
                                mem_raddr = FB_AW'(i_q_cmd.addr);
                                n_state   = S_RMW;
                            end
                            rpwdr_pkg::REQ_READ: begin
                                mem_re    = 1'b1;
                                mem_raddr = FB_AW'(i_q_cmd.addr);
                                n_state   = S_READ;
                            end
                            rpwdr_pkg::REQ_FILL: begin
                                n_fill_idx = '0;
                                if (i_geom.buf_bytes == '0) begin
                                    n_dirty = full_dirty;
                                    finish  = 1'b1;
                                end else begin
                                    n_state = S_FILL;
                                end
                            end
                            default: begin
                                n_dirty = '0;
                                finish  = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_RMW: begin
                mem_we    = 1'b1;
                mem_waddr = FB_AW'(r_cmd.addr);
                mem_wdata = r_cmd.color ? (r_rd_data | pix_mask) : (r_rd_data & ~pix_mask);
                n_dirty   = mg_dirty;
                finish    = 1'b1;
            end
            S_READ: begin
                n_rdata = r_rd_data;
                finish  = 1'b1;
            end
            S_FILL: begin
                mem_we     = 1'b1;
                mem_waddr  = FB_AW'(r_fill_idx);
                mem_wdata  = {8{r_cmd.color}};
                n_fill_idx = r_fill_idx + rpwdr_pkg::BYTES_W'(1);
                if (r_fill_idx == i_geom.buf_bytes - rpwdr_pkg::BYTES_W'(1)) begin
                    n_dirty = full_dirty;
                    finish  = 1'b1;
                end
            end
            S_EMIT: begin
                finish = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // Result goes to the output register now, or waits for it to free up.
        if (finish) begin
            if (out_free) begin
                n_out_vld = 1'b1;
                n_out     = '{status: n_status, rdata: n_rdata, dirty: n_dirty};
                n_state   = S_IDLE;
            end else begin
                n_state = S_EMIT;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_init_idx <= '0;
            r_dirty    <= rpwdr_pkg::DIRTY_RST;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_init_idx <= n_init_idx;
            r_dirty    <= n_dirty;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_fill_idx <= n_fill_idx;
        r_cmd      <= n_cmd;
        r_status   <= n_status;
        r_rdata    <= n_rdata;
        r_out      <= n_out;
    end

    // Frame store with a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // A cleared rectangle is empty and sits at the origin.
    a_empty_rect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_dirty.vld |-> (r_dirty.w == '0 && r_dirty.h == '0
                          && r_dirty.x == '0 && r_dirty.y == '0))
        else $error("cleared dirty rectangle is not empty");

    // No result leaves before the clearing pass is done.
    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !r_out_vld)
        else $error("result during clearing pass");

    // Only a good draw reaches the read-modify-write step.
    a_rmw_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW) |-> (r_cmd.op == rpwdr_pkg::REQ_DRAW && !r_cmd.err))
        else $error("read-modify-write for a command that is not a good draw");

    // The fill walk only runs for a good fill command.
    a_fill_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_cmd.op == rpwdr_pkg::REQ_FILL && !r_cmd.err))
        else $error("fill walk for a command that is not a good fill");

endmodule

/* verif/pixel_writer_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// pixel_writer_checker: result checker for the rotated pixel writer
// Watches the register port and both streams, keeps its own copy of the
// framebuffer, the panel settings and the dirty rectangle, works out the
// result of every accepted request and compares it, field by field, with the
// result beats that the block sends back in order.
// ============================================================================
module pixel_writer_checker
    import rpwdr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    // Request data: pos_x[9:0], pos_y[19:10], color[27:20], byte_addr[42:28]
    input  logic [47:0]          i_req_data,
    // Request user field: req_type[1:0]
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    // Result data: status[0], read_data[8:1], dirty_flag[9], dirty_left[18:10],
    //              dirty_top[27:19], dirty_width[37:28], dirty_height[47:38]
    input  logic [47:0]          i_res_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 8'd1;
    localparam logic               STATUS_OK   = 1'b0;
    localparam logic               STATUS_ERR  = 1'b1;

    typedef struct packed {
        logic               status;
        logic [COLOR_W-1:0] rdata;
        logic               flag;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } pixel_result_t;

    // Mirror of the block's state.
    logic [7:0]       frame_bytes [FB_BYTES_DEF];
    logic [1:0]       panel_rot;
    logic [DIM_W-1:0] panel_w;
    logic [DIM_W-1:0] panel_h;
    logic             dirty_on;
    int unsigned      dirty_x0;
    int unsigned      dirty_y0;
    int unsigned      dirty_w;
    int unsigned      dirty_h;

    pixel_result_t pending_results [$];
    pixel_result_t want_result;
    pixel_result_t got_result;
    int            fail_count;
    int            beat_count;

    assign o_fail_count = fail_count;

    // Apply one request to the mirrored state and return the result it gives.
    function automatic pixel_result_t apply_request(t_req op, logic [9:0] px,
                                                    logic [9:0] py,
                                                    logic [7:0] color,
                                                    logic [14:0] addr);
        pixel_result_t res;
        int unsigned   ew, eh, stride, nbytes, lw, lh, nx, ny, a;
        int unsigned   hi_x, hi_y;
        logic [7:0]    mask;
        logic          ok;
        logic [7:0]    data;
        ew     = (panel_w > MAX_WIDTH) ? MAX_WIDTH : panel_w;
        eh     = (panel_h > MAX_HEIGHT) ? MAX_HEIGHT : panel_h;
        stride = (ew + 7) / 8;
        nbytes = stride * eh;
        if (nbytes > FB_BYTES_DEF) begin
            nbytes = FB_BYTES_DEF;
        end
        ok   = 1'b1;
        data = 8'h00;
        case (op)
            REQ_DRAW: begin
                lw = panel_rot[0] ? eh : ew;
                lh = panel_rot[0] ? ew : eh;
                if (color > COLOR_WHITE || px >= lw || py >= lh) begin
                    ok = 1'b0;
                end else begin
                    // Map the logical point to native panel coordinates.
                    case (panel_rot)
                        ROT_0: begin
                            nx = px;
                            ny = py;
                        end
                        ROT_90: begin
                            nx = ew - 1 - py;
                            ny = px;
                        end
                        ROT_180: begin
                            nx = ew - 1 - px;
                            ny = eh - 1 - py;
                        end
                        default: begin
                            nx = py;
                            ny = eh - 1 - px;
                        end
                    endcase
                    a = ny * stride + (nx >> 3);
                    if (a >= FB_BYTES_DEF) begin
                        ok = 1'b0;
                    end else begin
                        mask = 8'h80 >> (nx & 7);
                        if (color == COLOR_WHITE) begin
                            frame_bytes[a] = frame_bytes[a] | mask;
                        end else begin
                            frame_bytes[a] = frame_bytes[a] & ~mask;
                        end
                        // Grow the dirty rectangle to cover the pixel.
                        if (!dirty_on) begin
                            dirty_x0 = nx;
                            dirty_y0 = ny;
                            dirty_w  = 1;
                            dirty_h  = 1;
                            dirty_on = 1'b1;
                        end else begin
                            hi_x = (nx + 1 > dirty_x0 + dirty_w) ? nx + 1 : dirty_x0 + dirty_w;
                            hi_y = (ny + 1 > dirty_y0 + dirty_h) ? ny + 1 : dirty_y0 + dirty_h;
                            if (nx < dirty_x0) begin
                                dirty_x0 = nx;
                            end
                            if (ny < dirty_y0) begin
                                dirty_y0 = ny;
                            end
                            dirty_w = hi_x - dirty_x0;
                            dirty_h = hi_y - dirty_y0;
                        end
                    end
                end
            end
            REQ_FILL: begin
                if (color > COLOR_WHITE) begin
                    ok = 1'b0;
                end else begin
                    for (int i = 0; i < nbytes; i++) begin
                        frame_bytes[i] = (color == COLOR_WHITE) ? 8'hFF : 8'h00;
                    end
                    dirty_x0 = 0;
                    dirty_y0 = 0;
                    dirty_w  = ew;
                    dirty_h  = eh;
                    dirty_on = 1'b1;
                end
            end
            REQ_CLEAR: begin
                dirty_x0 = 0;
                dirty_y0 = 0;
                dirty_w  = 0;
                dirty_h  = 0;
                dirty_on = 1'b0;
            end
            default: begin
                if (addr < nbytes) begin
                    data = frame_bytes[addr];
                end else begin
                    ok = 1'b0;
                end
            end
        endcase
        res.status = ok ? STATUS_OK : STATUS_ERR;
        res.rdata  = data;
        res.flag   = dirty_on;
        res.left   = COORD_W'(dirty_x0);
        res.top    = COORD_W'(dirty_y0);
        res.width  = DIM_W'(dirty_w);
        res.height = DIM_W'(dirty_h);
        return res;
    endfunction

    task automatic check_field(string field, logic [9:0] exp_v, logic [9:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("result beat %0d: %s expected 0x%0h, got 0x%0h",
                         beat_count, field, exp_v, act_v);
            end
        end
    endtask

    // Track registers, predict on request beats and check result beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FB_BYTES_DEF; i++) begin
                frame_bytes[i] = 8'hFF;
            end
            panel_rot = ROT_0;
            panel_w   = DIM_W'(RST_WIDTH);
            panel_h   = DIM_W'(RST_HEIGHT);
            dirty_on  = 1'b1;
            dirty_x0  = 0;
            dirty_y0  = 0;
            dirty_w   = RST_WIDTH;
            dirty_h   = RST_HEIGHT;
            pending_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROTATION: panel_rot = i_cfg_data[1:0];
                    CFG_WIDTH:    panel_w   = i_cfg_data;
                    CFG_HEIGHT:   panel_h   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                pending_results.push_back(apply_request(t_req'(i_req_type),
                    i_req_data[9:0], i_req_data[19:10], i_req_data[27:20],
                    i_req_data[42:28]));
            end
            if (i_res_valid && i_res_ready) begin
                got_result.status = i_res_data[0];
                got_result.rdata  = i_res_data[8:1];
                got_result.flag   = i_res_data[9];
                got_result.left   = i_res_data[18:10];
                got_result.top    = i_res_data[27:19];
                got_result.width  = i_res_data[37:28];
                got_result.height = i_res_data[47:38];
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("result beat %0d arrived with no request waiting: 0x%0h",
                                 beat_count, i_res_data);
                    end
                end else begin
                    want_result = pending_results.pop_front();
                    check_field("status", 10'(want_result.status), 10'(got_result.status));
                    check_field("read_data", 10'(want_result.rdata), 10'(got_result.rdata));
                    check_field("dirty_flag", 10'(want_result.flag), 10'(got_result.flag));
                    check_field("dirty_left", 10'(want_result.left), 10'(got_result.left));
                    check_field("dirty_top", 10'(want_result.top), 10'(got_result.top));
                    check_field("dirty_width", want_result.width, got_result.width);
                    check_field("dirty_height", want_result.height, got_result.height);
                end
                beat_count++;
            end
            o_pending <= pending_results.size();
        end
    end

endmodule

/* verif/rotated_pixel_writer_dirty_rect_top_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// rotated_pixel_writer_dirty_rect_top_tb: testbench for the pixel writer
// Drives directed requests at the reset panel settings, then random requests
// over a series of panel sizes and rotations, including zero, oversized and
// maximum panels, with random gaps on the request side and random stalls on
// the result side. The checker module does the prediction and comparison.
// ============================================================================
module rotated_pixel_writer_dirty_rect_top_tb;
    import rpwdr_pkg::*;

    localparam int unsigned       RUN_LIMIT   = 3000000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 8'd0;
    localparam logic [COLOR_W-1:0] COLOR_WHITE = 8'd1;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = CFG_ROTATION;
    logic [DIM_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata  = '0;
    logic [REQ_W-1:0]     s_axis_tuser  = REQ_DRAW;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;

    int          fail_total;
    int          pending;
    int unsigned cycle_count = 0;
    bit          tx_idle_on  = 1'b1;
    bit          rx_idle_on  = 1'b1;
    int          big_fills   = 0;

    // Panel settings last written, used only to shape the stimulus.
    logic [1:0]       cur_rot = ROT_0;
    logic [DIM_W-1:0] cur_w   = DIM_W'(RST_WIDTH);
    logic [DIM_W-1:0] cur_h   = DIM_W'(RST_HEIGHT);

    rotated_pixel_writer_dirty_rect_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pixel_writer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_type   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_fail_count (fail_total),
        .o_pending    (pending)
    );

    initial begin
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    // Give up on a run that hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: stall a random number of cycles before each beat.
    initial begin : result_sink
        int stall;
        forever begin
            stall = rx_idle_on ? $urandom_range(0, 8) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Send one request beat after a random gap; tvalid stays high afterwards.
    task automatic send_req(t_req op, logic [9:0] px, logic [9:0] py,
                            logic [7:0] color, logic [14:0] addr);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, addr, color, py, px};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stop sending and wait until every result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_panel(logic [1:0] rot, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        cur_rot = rot;
        cur_w   = w;
        cur_h   = h;
        cfg_put(CFG_ROTATION, DIM_W'(rot));
        cfg_put(CFG_WIDTH, w);
        cfg_put(CFG_HEIGHT, h);
        i_cfg_we <= 1'b0;
    endtask

    // One random request, mostly valid for the current panel.
    task automatic send_random();
        int unsigned ew, eh, lw, lh, nbytes, pick, coord;
        logic [9:0]  px, py;
        logic [7:0]  color;
        logic [14:0] addr;
        t_req        op;
        ew     = (cur_w > MAX_WIDTH) ? MAX_WIDTH : cur_w;
        eh     = (cur_h > MAX_HEIGHT) ? MAX_HEIGHT : cur_h;
        lw     = cur_rot[0] ? eh : ew;
        lh     = cur_rot[0] ? ew : eh;
        nbytes = ((ew + 7) / 8) * eh;
        px     = 10'($urandom);
        py     = 10'($urandom);
        color  = 8'($urandom);
        addr   = 15'($urandom);
        pick   = $urandom_range(0, 99);
        coord  = $urandom_range(0, 9);
        if (pick < 50) begin
            op = REQ_DRAW;
            if (coord == 1 || coord == 2) begin
                // One coordinate on or just past the logical edge.
                px = (lw > 0) ? 10'($urandom_range(0, lw - 1)) : px;
                py = (lh > 0) ? 10'($urandom_range(0, lh - 1)) : py;
                if (coord == 1) begin
                    px = 10'(lw - $urandom_range(0, 1));
                end else begin
                    py = 10'(lh - $urandom_range(0, 1));
                end
            end else if (coord >= 3 && lw > 0 && lh > 0) begin
                px = 10'($urandom_range(0, lw - 1));
                py = 10'($urandom_range(0, lh - 1));
            end
            if ($urandom_range(0, 15) != 0) begin
                color = 8'($urandom_range(0, 1));
            end
        end else if (pick < 58) begin
            op = REQ_CLEAR;
        end else if (pick < 61) begin
            op = REQ_FILL;
            if ($urandom_range(0, 3) != 0) begin
                color = 8'($urandom_range(0, 1));
            end
            // Full fills of large panels are slow, so allow only a few.
            if (color <= COLOR_WHITE && nbytes > 1024) begin
                if (big_fills < 3) begin
                    big_fills++;
                end else begin
                    color = 8'($urandom_range(2, 255));
                end
            end
        end else begin
            op = REQ_READ;
            if (coord == 1) begin
                addr = 15'(nbytes - $urandom_range(0, 1));
            end else if (coord >= 2 && nbytes > 0) begin
                addr = 15'($urandom_range(0, nbytes - 1));
            end
        end
        send_req(op, px, py, color, addr);
    endtask

    // Reset, directed requests, random phases and the verdict.
    initial begin : stimulus
        logic [1:0]       rot;
        logic [DIM_W-1:0] w, h;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests at the reset panel of 400 by 300.
        send_req(REQ_READ, 10'($urandom), 10'($urandom), 8'($urandom), 15'd0);
        send_req(REQ_READ, 10'($urandom), 10'($urandom), 8'($urandom), 15'd14999);
        send_req(REQ_READ, 10'($urandom), 10'($urandom), 8'($urandom), 15'd15000);
        send_req(REQ_READ, 10'($urandom), 10'($urandom), 8'($urandom), 15'h7FFF);
        send_req(REQ_CLEAR, 10'($urandom), 10'($urandom), 8'($urandom), 15'($urandom));
        send_req(REQ_DRAW, 10'd0, 10'd0, COLOR_BLACK, 15'($urandom));
        send_req(REQ_DRAW, 10'd399, 10'd299, COLOR_BLACK, 15'($urandom));
        send_req(REQ_DRAW, 10'd400, 10'd0, COLOR_WHITE, 15'($urandom));
        send_req(REQ_DRAW, 10'd0, 10'd300, COLOR_WHITE, 15'($urandom));
        send_req(REQ_DRAW, 10'h3FF, 10'h3FF, COLOR_WHITE, 15'h7FFF);
        send_req(REQ_DRAW, 10'd5, 10'd5, 8'd2, 15'($urandom));
        send_req(REQ_DRAW, 10'd5, 10'd5, 8'hFF, 15'($urandom));
        send_req(REQ_READ, 10'($urandom), 10'($urandom), 8'($urandom), 15'd0);
        send_req(REQ_READ, 10'($urandom), 10'($urandom), 8'($urandom), 15'd14999);
        send_req(REQ_DRAW, 10'd0, 10'd0, COLOR_WHITE, 15'd0);
        send_req(REQ_FILL, 10'($urandom), 10'($urandom), 8'hFF, 15'($urandom));
        send_req(REQ_FILL, 10'($urandom), 10'($urandom), COLOR_BLACK, 15'($urandom));
        send_req(REQ_READ, 10'($urandom), 10'($urandom), 8'($urandom), 15'd7);
        send_req(REQ_READ, 10'($urandom), 10'($urandom), 8'($urandom), 15'd15000);
        send_req(REQ_FILL, 10'($urandom), 10'($urandom), COLOR_WHITE, 15'($urandom));
        send_req(REQ_CLEAR, 10'($urandom), 10'($urandom), 8'($urandom), 15'($urandom));
        send_req(REQ_READ, 10'($urandom), 10'($urandom), 8'($urandom), 15'd123);
        drain();

        // The unused register index must leave everything alone.
        cfg_put(CFG_SPARE, DIM_W'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);

        // Random phases over a range of panels and rotations.
        for (int phase = 0; phase < 12; phase++) begin
            case (phase)
                0:  begin rot = ROT_90;  w = 10'd400;  h = 10'd300;  end
                1:  begin rot = ROT_180; w = 10'd17;   h = 10'd9;    end
                2:  begin rot = ROT_270; w = 10'd8;    h = 10'd1;    end
                3:  begin rot = ROT_0;   w = 10'd1;    h = 10'd1;    end
                4:  begin rot = ROT_90;  w = 10'd0;    h = 10'd5;    end
                5:  begin rot = ROT_180; w = 10'd5;    h = 10'd0;    end
                6:  begin rot = ROT_270; w = 10'h3FF;  h = 10'd3;    end
                7:  begin rot = ROT_0;   w = 10'd3;    h = 10'h3FF;  end
                8:  begin rot = ROT_90;  w = 10'd512;  h = 10'd512;  end
                9:  begin rot = ROT_180; w = 10'd13;   h = 10'd7;    end
                default: begin
                    rot = 2'($urandom);
                    w   = 10'($urandom_range(1, 48));
                    h   = 10'($urandom_range(1, 48));
                end
            endcase
            set_panel(rot, w, h);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            repeat (90) send_random();
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (fail_total == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* rotated_pixel_writer_dirty_rect_top.f */
design/rpwdr_pkg.sv
design/rpwdr_front.sv
design/rpwdr_queue.sv
design/rpwdr_back.sv
design/rotated_pixel_writer_dirty_rect_top.sv
verif/pixel_writer_checker.sv
verif/rotated_pixel_writer_dirty_rect_top_tb.sv
